[src/mhpq_pkg.sv]
// Shared constants and types for the max-heap priority queue.
// No dependencies; imported by the RAM-facing top level.
package mhpq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = ADDR_W + 2;
  localparam int OUT_CNT_W = 11;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

endpackage

[src/mhpq_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No package dependencies.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                        rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                        rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[src/max_heap_priority_queue.sv]
// Max-heap priority queue: one result per transaction, inserts and remove-max.
// Insert sifts the new value up from the end of the heap; remove returns the root and,
// unless it took the only entry, sifts the last entry down from the root; a full or
// empty error finishes without touching the RAM. Throughput: one transaction at a time;
// the next is taken while a result waits. Reset: synchronous active-low rst_n empties
// the heap; the RAM is not cleared. Depends on mhpq_pkg and mhpq_ram.
module max_heap_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  mhpq_pkg::data_t                   in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mhpq_pkg::data_t                   out_removed_value,
  output logic                              out_removed_ok,
  output logic                              out_empty_error,
  output logic                              out_full_error,
  output mhpq_pkg::data_t                   out_top_value,
  output logic                              out_top_valid,
  output logic [mhpq_pkg::OUT_CNT_W-1:0]    out_entry_count
);
  import mhpq_pkg::*;

  // Controller states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a transaction
  localparam logic [2:0] S_UP    = 3'd1;  // sift-up: compare parent, move hole up
  localparam logic [2:0] S_UPW   = 3'd2;  // sift-up reached the root: drop value there
  localparam logic [2:0] S_DLAST = 3'd3;  // remove: last entry arrives from RAM
  localparam logic [2:0] S_DN    = 3'd4;  // sift-down: compare children, move hole down
  localparam logic [2:0] S_FIN   = 3'd5;  // hand the result to the output register

  logic [2:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;       // stored entries
  addr_t      pos_r, pos_nxt;       // hole position
  data_t      v_r, v_nxt;           // value being sifted
  data_t      top_r;                // shadow of entry 0

  // Result of the transaction in flight
  data_t res_rem_r, res_rem_nxt;
  logic  res_ok_r, res_ok_nxt;
  logic  res_empty_r, res_empty_nxt;
  logic  res_full_r, res_full_nxt;

  // Output register
  logic                 out_valid_r;
  data_t                out_rem_r;
  logic                 out_ok_r, out_empty_r, out_full_r;
  data_t                out_top_r;
  logic                 out_top_valid_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;

  // RAM ports
  logic  we;
  addr_t waddr, raddr_a, raddr_b;
  data_t wdata;
  logic [DATA_W-1:0] rd_a_raw, rd_b_raw;
  data_t rd_a, rd_b;

  assign rd_a = data_t'(rd_a_raw);
  assign rd_b = data_t'(rd_b_raw);

  mhpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a_raw),
    .raddr_b (raddr_b),
    .rdata_b (rd_b_raw)
  );

  // Index helpers for the sift steps
  logic [IDX_W-1:0] lft_idx, rgt_idx, n_idx;
  addr_t            par_idx;
  logic             l_ok, r_ok, take_l, take_r, dn_swap;
  addr_t            best_idx;
  data_t            best_val;
  logic [ADDR_W:0]  nl_idx;
  logic             fin_go;

  assign lft_idx = {1'b0, pos_r, 1'b1};
  assign rgt_idx = lft_idx + IDX_W'(1);
  assign n_idx   = IDX_W'(cnt_r);
  assign par_idx = addr_t'(pos_r - addr_t'(1)) >> 1;

  // Pick the larger child; left wins a tie, swap only on strictly greater
  assign l_ok     = lft_idx < n_idx;
  assign r_ok     = rgt_idx < n_idx;
  assign take_l   = l_ok && (rd_a > v_r);
  assign take_r   = r_ok && (rd_b > (take_l ? rd_a : v_r));
  assign dn_swap  = take_l || take_r;
  assign best_idx = take_r ? rgt_idx[ADDR_W-1:0] : lft_idx[ADDR_W-1:0];
  assign best_val = take_r ? rd_b : rd_a;
  assign nl_idx   = {best_idx, 1'b1};

  assign in_ready = (state_r == S_IDLE);
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    v_nxt         = v_r;
    res_rem_nxt   = res_rem_r;
    res_ok_nxt    = res_ok_r;
    res_empty_nxt = res_empty_r;
    res_full_nxt  = res_full_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = v_r;
    raddr_a       = '0;
    raddr_b       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_rem_nxt   = '0;
          res_ok_nxt    = 1'b0;
          res_empty_nxt = 1'b0;
          res_full_nxt  = 1'b0;
          state_nxt     = S_FIN;
          if (in_cmd == CMD_INSERT) begin
            if (cnt_r >= cnt_t'(CAPACITY)) begin
              res_full_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_r + cnt_t'(1);
              v_nxt   = in_value;
              pos_nxt = addr_t'(cnt_r);
              if (cnt_r == '0) begin
                // Empty heap: the value is the root
                we    = 1'b1;
                waddr = '0;
                wdata = in_value;
              end else begin
                raddr_a   = addr_t'(addr_t'(cnt_r) - addr_t'(1)) >> 1;
                state_nxt = S_UP;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              res_empty_nxt = 1'b1;
            end else begin
              res_rem_nxt = top_r;
              res_ok_nxt  = 1'b1;
              cnt_nxt     = cnt_r - cnt_t'(1);
              if (cnt_r != cnt_t'(1)) begin
                // Fetch the last entry to refill the root
                raddr_a   = addr_t'(cnt_r - cnt_t'(1));
                state_nxt = S_DLAST;
              end
            end
          end
        end
      end
      S_UP: begin
        we = 1'b1;
        if (rd_a < v_r) begin
          // Move the parent down into the hole
          waddr   = pos_r;
          wdata   = rd_a;
          pos_nxt = par_idx;
          if (par_idx == '0) begin
            state_nxt = S_UPW;
          end else begin
            raddr_a = addr_t'(par_idx - addr_t'(1)) >> 1;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UPW: begin
        we        = 1'b1;
        state_nxt = S_FIN;
      end
      S_DLAST: begin
        v_nxt     = rd_a;
        pos_nxt   = '0;
        raddr_a   = addr_t'(1);
        raddr_b   = addr_t'(2);
        state_nxt = S_DN;
      end
      S_DN: begin
        we = 1'b1;
        if (dn_swap) begin
          // Move the winning child up into the hole
          wdata   = best_val;
          pos_nxt = best_idx;
          raddr_a = nl_idx[ADDR_W-1:0];
          raddr_b = addr_t'(nl_idx + (ADDR_W+1)'(1));
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    v_r         <= v_nxt;
    res_rem_r   <= res_rem_nxt;
    res_ok_r    <= res_ok_nxt;
    res_empty_r <= res_empty_nxt;
    res_full_r  <= res_full_nxt;
    // Track entry 0 so the top is known without a RAM read
    if (we && (waddr == '0)) begin
      top_r <= wdata;
    end
    if (fin_go) begin
      out_rem_r       <= res_rem_r;
      out_ok_r        <= res_ok_r;
      out_empty_r     <= res_empty_r;
      out_full_r      <= res_full_r;
      out_top_r       <= (cnt_r != '0) ? top_r : '0;
      out_top_valid_r <= (cnt_r != '0);
      out_cnt_r       <= OUT_CNT_W'(cnt_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_rem_r;
  assign out_removed_ok    = out_ok_r;
  assign out_empty_error   = out_empty_r;
  assign out_full_error    = out_full_r;
  assign out_top_value     = out_top_r;
  assign out_top_valid     = out_top_valid_r;
  assign out_entry_count   = out_cnt_r;

  // Count never exceeds the heap size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  // A new result only comes out of the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside finish state");

  // At most one status flag per result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_ok_r, out_empty_r, out_full_r}))
    else $error("conflicting status flags");

  // Top is valid exactly when the heap is not empty
  a_top_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_top_valid_r == (out_cnt_r != '0)))
    else $error("top_valid disagrees with entry count");

  // Sift-down never starts on an empty heap
  a_dn_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DLAST) |-> (cnt_r != '0))
    else $error("sift-down with no entries");

endmodule

[dv/tb.sv]
// Self-checking testbench for the max-heap priority queue (max_heap_priority_queue).
// Keeps its own heap to predict each result, drives inserts and removes, and checks every result.
// Depends on mhpq_pkg and the RTL under src/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  // One result transaction as the block reports it.
  typedef struct {
    data_t                removed_value;
    logic                 removed_ok;
    logic                 empty_error;
    logic                 full_error;
    data_t                top_value;
    logic                 top_valid;
    logic [OUT_CNT_W-1:0] entry_count;
  } heap_result_t;

  localparam data_t VAL_MAX = 32'sh7fff_ffff;
  localparam data_t VAL_MIN = 32'sh8000_0000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  data_t                in_value;
  logic                 out_valid;
  logic                 out_ready;
  data_t                out_removed_value;
  logic                 out_removed_ok;
  logic                 out_empty_error;
  logic                 out_full_error;
  data_t                out_top_value;
  logic                 out_top_valid;
  logic [OUT_CNT_W-1:0] out_entry_count;

  // Shadow copy of the heap, updated in order of accepted transactions.
  data_t        heap_model [CAPACITY];
  int unsigned  heap_size;
  heap_result_t pending_heap_results [$];

  int fail_count;
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold_cycles;

  max_heap_priority_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_removed_ok    (out_removed_ok),
    .out_empty_error   (out_empty_error),
    .out_full_error    (out_full_error),
    .out_top_value     (out_top_value),
    .out_top_valid     (out_top_valid),
    .out_entry_count   (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; a correct run takes well under a fifth of this.
  initial begin
    #10_000_000;
    $display("** max_heap_priority_queue: FAILED **");
    $finish;
  end

  // Apply one operation to the shadow heap and return what the block must report.
  function automatic heap_result_t heap_apply(logic cmd, data_t value);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  parent;
    int unsigned  left;
    int unsigned  right;
    int unsigned  best;
    data_t        tmp;
    bit           settled;
    r.removed_value = '0;
    r.removed_ok    = 1'b0;
    r.empty_error   = 1'b0;
    r.full_error    = 1'b0;
    if (cmd == CMD_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.full_error = 1'b1;
      end else begin
        // Append, then bubble up while the parent is strictly smaller.
        heap_model[heap_size] = value;
        pos = heap_size;
        heap_size++;
        settled = 1'b0;
        while (pos != 0 && !settled) begin
          parent = (pos - 1) / 2;
          if (heap_model[parent] < heap_model[pos]) begin
            tmp                = heap_model[parent];
            heap_model[parent] = heap_model[pos];
            heap_model[pos]    = tmp;
            pos                = parent;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end else begin
      if (heap_size == 0) begin
        r.empty_error = 1'b1;
      end else begin
        r.removed_value = heap_model[0];
        r.removed_ok    = 1'b1;
        heap_size--;
        heap_model[0] = heap_model[heap_size];
        // Sink the new root; the left child wins a tie, swap only on strictly greater.
        pos     = 0;
        settled = 1'b0;
        while (!settled) begin
          left  = 2 * pos + 1;
          right = 2 * pos + 2;
          best  = pos;
          if (left < heap_size && heap_model[left] > heap_model[best]) best = left;
          if (right < heap_size && heap_model[right] > heap_model[best]) best = right;
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            tmp              = heap_model[pos];
            heap_model[pos]  = heap_model[best];
            heap_model[best] = tmp;
            pos              = best;
          end
        end
      end
    end
    r.top_valid   = (heap_size != 0);
    r.top_value   = (heap_size != 0) ? heap_model[0] : '0;
    r.entry_count = heap_size[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic signed [32:0] exp_v,
                                        logic signed [32:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Mostly full-range values, with extremes and a narrow band to force ties.
  function automatic data_t rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return data_t'($urandom_range(0, 8)) - 4;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Offer one transaction and hold it until accepted; valid stays high for the next one.
  task automatic issue_op(input logic cmd, input data_t value);
    int           gap;
    heap_result_t exp_r;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_r = heap_apply(cmd, value);
    pending_heap_results.insert(pending_heap_results.size(), exp_r);
  endtask

  // Drop valid and wait until every predicted result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_heap_results.size() != 0) @(posedge clk);
  endtask

  // Check each result transaction and drive out_ready with random stall bursts.
  initial begin : result_monitor
    heap_result_t exp_r;
    int           rx_stall;
    rx_stall  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_heap_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_count++;
        end else begin
          exp_r = pending_heap_results.pop_front();
          compare_field("removed_value", exp_r.removed_value, out_removed_value);
          compare_field("removed_ok",    exp_r.removed_ok,    out_removed_ok);
          compare_field("empty_error",   exp_r.empty_error,   out_empty_error);
          compare_field("full_error",    exp_r.full_error,    out_full_error);
          compare_field("top_value",     exp_r.top_value,     out_top_value);
          compare_field("top_valid",     exp_r.top_valid,     out_top_valid);
          compare_field("entry_count",   exp_r.entry_count,   out_entry_count);
        end
      end
      // A long hold wins over ordinary stall bursts.
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Extremes, ties, ignored value on remove, and removes on an empty heap.
  task automatic test_directed();
    issue_op(CMD_REMOVE, 32'sd0);
    issue_op(CMD_INSERT, 32'sd0);
    issue_op(CMD_INSERT, VAL_MAX);
    issue_op(CMD_INSERT, VAL_MIN);
    issue_op(CMD_INSERT, -32'sd1);
    issue_op(CMD_INSERT, 32'sd1);
    issue_op(CMD_INSERT, 32'sd1);
    issue_op(CMD_INSERT, 32'sd1);
    issue_op(CMD_REMOVE, VAL_MAX);
    issue_op(CMD_REMOVE, VAL_MIN);
    issue_op(CMD_REMOVE, 32'sh5555_5555);
    issue_op(CMD_REMOVE, 32'sd0);
    issue_op(CMD_INSERT, 32'sh5555_5555);
    issue_op(CMD_INSERT, 32'shaaaa_aaaa);
    issue_op(CMD_REMOVE, 32'shffff_ffff);
    issue_op(CMD_REMOVE, 32'sd0);
    issue_op(CMD_REMOVE, 32'sd0);
    issue_op(CMD_REMOVE, 32'sd0);
    issue_op(CMD_REMOVE, 32'sd0);
    issue_op(CMD_REMOVE, 32'sd0);
    issue_op(CMD_REMOVE, VAL_MAX);
    wait_drained();
  endtask

  // Start a long receiver hold, fill to capacity, overflow, then take out a batch of maxima.
  task automatic test_fill_and_drain();
    rx_hold_cycles = 300;
    repeat (CAPACITY) issue_op(CMD_INSERT, rand_value());
    issue_op(CMD_INSERT, rand_value());
    issue_op(CMD_INSERT, VAL_MAX);
    repeat (64) issue_op(CMD_REMOVE, data_t'($urandom));
    wait_drained();
  endtask

  // Alternate growing and shrinking phases so the heap depth keeps changing.
  task automatic test_random_mix(input int n_items);
    int grow_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) grow_pct = ((i / 50) % 2 == 0) ? 75 : 30;
      if ($urandom_range(0, 99) < grow_pct) issue_op(CMD_INSERT, rand_value());
      else issue_op(CMD_REMOVE, data_t'($urandom));
      // Pause the sender once midway until the block has answered everything.
      if (i == n_items / 2) wait_drained();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming(input int n_items);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 1) == 0) issue_op(CMD_INSERT, rand_value());
      else issue_op(CMD_REMOVE, data_t'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    fail_count     = 0;
    heap_size      = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rx_hold_cycles = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_cmd   <= CMD_INSERT;
    in_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_mix(160);
    test_streaming(60);

    // Let any late or spurious result show up before the verdict.
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_heap_results.size() == 0) begin
      $display("** max_heap_priority_queue: PASSED **");
    end else begin
      $display("** max_heap_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/max_heap_priority_queue.sv
dv/tb.sv
